FILE: rtl/core/metb_pkg.sv
package metb_pkg;

    // one stored edge: vertex pair plus up to two faces (63 bits)
    typedef struct packed {
        logic [14:0] lo;
        logic [14:0] hi;
        logic        two;      // 1: two faces recorded
        logic [12:0] seg0;
        logic [2:0]  sid0;
        logic [12:0] seg1;
        logic [2:0]  sid1;
    } edge_entry_t;

    localparam int unsigned ENTRY_W = $bits(edge_entry_t);

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_JOINED   = 3'd1,
        ST_SPLIT    = 3'd2,
        ST_FULL     = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_BEYOND   = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DECIDE,
        S_COPY_RD,
        S_COPY_CHK,
        S_COPY_WB,
        S_RESULT
    } fsm_t;

    // put the two faces in ascending (segment, side) order
    function automatic edge_entry_t order_faces(input edge_entry_t e);
        edge_entry_t r;
        r = e;
        if ((e.seg1 < e.seg0) || ((e.seg1 == e.seg0) && (e.sid1 < e.sid0)))
        begin
            r.seg0 = e.seg1;
            r.sid0 = e.sid1;
            r.seg1 = e.seg0;
            r.sid1 = e.sid0;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/metb_ram.sv
module metb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/mesh_edge_table_builder_core.sv
// channel | signals                     | direction | contents
// in      | in_valid / in_ready         | in        | action, segment, side, corners, edge_index
// out     | out_valid / out_ready       | out       | status, edge_count, entry fields
//
// Read: the store is read in the accept cycle, the entry is captured, then the result is handed off.
// Insert: a scan of the N stored entries, a decide step and, when a split appends copies, a
// pass over the stored entries from the first match on that reads, checks and writes the copies.
// The scan reads one entry per cycle through the single read port of the edge store.
// Reset clears the fill count and control; the store itself needs no clearing.
// A waiting result sits in the output register; out_ready low only delays it.
module mesh_edge_table_builder_core #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [12:0] segment,
    input  logic [2:0]  side,
    input  logic [14:0] corner_first,
    input  logic [14:0] corner_second,
    input  logic [9:0]  edge_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [10:0] edge_count,
    output logic [14:0] low_vertex,
    output logic [14:0] high_vertex,
    output logic [1:0]  face_count,
    output logic [12:0] first_segment,
    output logic [2:0]  first_side,
    output logic [12:0] second_segment,
    output logic [2:0]  second_side
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = CW + 11;   // room for count + 2*matches and the index

    metb_pkg::fsm_t        state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;      // scan / copy pointer
    logic [CW-1:0]         n_reg, n_next;          // append pointer
    logic [CW-1:0]         match_reg, match_next;
    logic [AW-1:0]         first_reg, first_next;
    logic [AW-1:0]         pidx_reg, pidx_next;
    logic                  pend_reg, pend_next;
    logic                  rdok_reg, rdok_next;
    logic [14:0]           lo_reg, lo_next, hi_reg, hi_next;
    logic [12:0]           seg_reg, seg_next;
    logic [2:0]            sid_reg, sid_next;
    metb_pkg::edge_entry_t first_dat_reg, first_dat_next;
    metb_pkg::edge_entry_t src_reg, src_next;
    metb_pkg::status_t     res_st_reg, res_st_next;
    metb_pkg::edge_entry_t res_e_reg, res_e_next;
    logic                  ov_reg, ov_next;
    metb_pkg::status_t     ost_reg, ost_next;
    logic [10:0]           ocnt_reg, ocnt_next;
    metb_pkg::edge_entry_t oe_reg, oe_next;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    metb_pkg::edge_entry_t ram_wdata, ram_rdata;
    logic [XW-1:0]         idx_ext;
    logic                  hit;
    metb_pkg::edge_entry_t tmp;

    metb_ram #(.WIDTH(metb_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_ext = XW'(edge_index);
    assign hit     = (ram_rdata.lo == lo_reg) && (ram_rdata.hi == hi_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            metb_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action == metb_pkg::ACT_READ) ? metb_pkg::S_READ
                                                                : metb_pkg::S_SCAN;
                end
            end
            metb_pkg::S_READ:   state_next = metb_pkg::S_RESULT;
            metb_pkg::S_SCAN:
            begin
                if ((idx_reg == count_reg) && !pend_reg)
                begin
                    state_next = metb_pkg::S_DECIDE;
                end
            end
            metb_pkg::S_DECIDE:
            begin
                if ((match_reg != '0) && first_dat_reg.two &&
                    ((XW'(count_reg) + (XW'(match_reg) << 1)) <= XW'(CAPACITY)))
                begin
                    state_next = metb_pkg::S_COPY_RD;
                end
                else
                begin
                    state_next = metb_pkg::S_RESULT;
                end
            end
            metb_pkg::S_COPY_RD:
            begin
                state_next = (idx_reg == count_reg) ? metb_pkg::S_RESULT
                                                    : metb_pkg::S_COPY_CHK;
            end
            metb_pkg::S_COPY_CHK:
            begin
                state_next = hit ? metb_pkg::S_COPY_WB : metb_pkg::S_COPY_RD;
            end
            metb_pkg::S_COPY_WB: state_next = metb_pkg::S_COPY_RD;
            metb_pkg::S_RESULT:
            begin
                if (!ov_reg || out_ready)
                begin
                    state_next = metb_pkg::S_IDLE;
                end
            end
            default: state_next = metb_pkg::S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        match_next     = match_reg;
        first_next     = first_reg;
        pidx_next      = pidx_reg;
        pend_next      = 1'b0;
        rdok_next      = rdok_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        seg_next       = seg_reg;
        sid_next       = sid_reg;
        first_dat_next = first_dat_reg;
        src_next       = src_reg;
        res_st_next    = res_st_reg;
        res_e_next     = res_e_reg;
        ov_next        = ov_reg && !out_ready;
        ost_next       = ost_reg;
        ocnt_next      = ocnt_reg;
        oe_next        = oe_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = n_reg[AW-1:0];
        ram_raddr      = idx_reg[AW-1:0];
        ram_wdata      = '0;
        in_ready       = (state_reg == metb_pkg::S_IDLE);
        tmp            = '0;

        unique case (state_reg)
            metb_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    lo_next    = (corner_first < corner_second) ? corner_first : corner_second;
                    hi_next    = (corner_first < corner_second) ? corner_second : corner_first;
                    seg_next   = segment;
                    sid_next   = side;
                    idx_next   = '0;
                    n_next     = count_reg;
                    match_next = '0;
                    rdok_next  = (idx_ext < XW'(count_reg)) && (idx_ext < XW'(CAPACITY));
                    ram_re     = (action == metb_pkg::ACT_READ);
                    ram_raddr  = AW'(idx_ext);
                end
            end
            metb_pkg::S_READ:
            begin
                res_st_next = rdok_reg ? metb_pkg::ST_READ_OK : metb_pkg::ST_BEYOND;
                res_e_next  = rdok_reg ? ram_rdata : '0;
            end
            metb_pkg::S_SCAN:
            begin
                // one read issued per cycle; the compare follows in the next cycle
                if (idx_reg != count_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                if (pend_reg && hit)
                begin
                    match_next = match_reg + 1'b1;
                    if (match_reg == '0)
                    begin
                        first_next     = pidx_reg;
                        first_dat_next = ram_rdata;
                    end
                end
            end
            metb_pkg::S_DECIDE:
            begin
                res_e_next = '0;
                if (match_reg == '0)
                begin
                    if (XW'(count_reg) >= XW'(CAPACITY))
                    begin
                        res_st_next = metb_pkg::ST_FULL;
                    end
                    else
                    begin
                        tmp.lo      = lo_reg;
                        tmp.hi      = hi_reg;
                        tmp.seg0    = seg_reg;
                        tmp.sid0    = sid_reg;
                        ram_we      = 1'b1;
                        ram_waddr   = count_reg[AW-1:0];
                        ram_wdata   = tmp;
                        count_next  = count_reg + 1'b1;
                        res_st_next = metb_pkg::ST_ADDED;
                    end
                end
                else if (!first_dat_reg.two)
                begin
                    tmp         = first_dat_reg;
                    tmp.two     = 1'b1;
                    tmp.seg1    = seg_reg;
                    tmp.sid1    = sid_reg;
                    ram_we      = 1'b1;
                    ram_waddr   = first_reg;
                    ram_wdata   = metb_pkg::order_faces(tmp);
                    res_st_next = metb_pkg::ST_JOINED;
                end
                else if ((XW'(count_reg) + (XW'(match_reg) << 1)) > XW'(CAPACITY))
                begin
                    res_st_next = metb_pkg::ST_FULL;
                end
                else
                begin
                    idx_next = CW'(first_reg);
                end
            end
            metb_pkg::S_COPY_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next  = n_reg;
                    res_st_next = metb_pkg::ST_SPLIT;
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            metb_pkg::S_COPY_CHK:
            begin
                if (hit)
                begin
                    // copy with the old first face replaced
                    tmp       = ram_rdata;
                    tmp.two   = 1'b1;
                    tmp.seg0  = seg_reg;
                    tmp.sid0  = sid_reg;
                    ram_we    = 1'b1;
                    ram_wdata = metb_pkg::order_faces(tmp);
                    n_next    = n_reg + 1'b1;
                    src_next  = ram_rdata;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            metb_pkg::S_COPY_WB:
            begin
                // copy with the old second face replaced
                tmp       = src_reg;
                tmp.two   = 1'b1;
                tmp.seg1  = seg_reg;
                tmp.sid1  = sid_reg;
                ram_we    = 1'b1;
                ram_wdata = metb_pkg::order_faces(tmp);
                n_next    = n_reg + 1'b1;
                idx_next  = idx_reg + 1'b1;
            end
            metb_pkg::S_RESULT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next   = 1'b1;
                    ost_next  = res_st_reg;
                    ocnt_next = 11'(count_reg);
                    oe_next   = res_e_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= metb_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        n_reg         <= n_next;
        match_reg     <= match_next;
        first_reg     <= first_next;
        pidx_reg      <= pidx_next;
        rdok_reg      <= rdok_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        seg_reg       <= seg_next;
        sid_reg       <= sid_next;
        first_dat_reg <= first_dat_next;
        src_reg       <= src_next;
        res_st_reg    <= res_st_next;
        res_e_reg     <= res_e_next;
        ost_reg       <= ost_next;
        ocnt_reg      <= ocnt_next;
        oe_reg        <= oe_next;
    end

    assign out_valid      = ov_reg;
    assign status         = ost_reg;
    assign edge_count     = ocnt_reg;
    assign low_vertex     = oe_reg.lo;
    assign high_vertex    = oe_reg.hi;
    assign face_count     = (ost_reg == metb_pkg::ST_READ_OK) ? (oe_reg.two ? 2'd2 : 2'd1)
                                                              : 2'd0;
    assign first_segment  = oe_reg.seg0;
    assign first_side     = oe_reg.sid0;
    assign second_segment = oe_reg.seg1;
    assign second_side    = oe_reg.sid1;

endmodule

FILE: rtl/core/metb_checker.sv
module metb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [14:0] low_vertex,
    input logic [14:0] high_vertex,
    input logic [1:0]  face_count,
    input logic [12:0] second_segment,
    input logic [2:0]  second_side
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result word changed while stalled");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != metb_pkg::ST_READ_OK) |->
            (low_vertex == '0) && (high_vertex == '0) && (face_count == '0))
        else $error("entry fields not zero on non-read status");

    a_faces: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == metb_pkg::ST_READ_OK) |->
            (face_count == 2'd1) || (face_count == 2'd2))
        else $error("bad face count on read");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == metb_pkg::ST_READ_OK) |-> low_vertex <= high_vertex)
        else $error("vertex pair out of order");

    a_one_face: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == metb_pkg::ST_READ_OK) && (face_count == 2'd1) |->
            (second_segment == '0) && (second_side == '0))
        else $error("second face set on one-face entry");

endmodule

bind mesh_edge_table_builder_core metb_checker u_metb_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

    // edge table model entry
    typedef struct {
        logic [14:0] lo;
        logic [14:0] hi;
        logic [1:0]  nfaces;
        logic [12:0] seg0;
        logic [2:0]  sid0;
        logic [12:0] seg1;
        logic [2:0]  sid1;
    } tbl_entry_t;

    typedef struct {
        metb_pkg::status_t st;
        logic [10:0] cnt;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [1:0]  nf;
        logic [12:0] seg0;
        logic [2:0]  sid0;
        logic [12:0] seg1;
        logic [2:0]  sid1;
    } edge_reply_t;

    localparam int TBL_DEPTH = 1024;

    // Table model plus queue of pending replies.
    class edge_table_sb;
        tbl_entry_t  tbl[TBL_DEPTH];
        int          used;
        edge_reply_t pending[$];
        int          errors;

        function void sort_faces(ref tbl_entry_t e);
            logic [12:0] ts;
            logic [2:0]  tsd;
            if (e.seg1 < e.seg0 || (e.seg1 == e.seg0 && e.sid1 < e.sid0))
            begin
                ts = e.seg0; e.seg0 = e.seg1; e.seg1 = ts;
                tsd = e.sid0; e.sid0 = e.sid1; e.sid1 = tsd;
            end
        endfunction

        function void note_word(logic act, logic [12:0] sg, logic [2:0] sd,
                                logic [14:0] va, logic [14:0] vb, logic [9:0] idx);
            edge_reply_t r;
            logic [14:0] lo, hi;
            int          first, hits, n;
            tbl_entry_t  src, cp;
            r = '{st: metb_pkg::ST_ADDED, default: '0};
            if (act == metb_pkg::ACT_READ) begin
                if (idx < used) begin
                    r.st = metb_pkg::ST_READ_OK;
                    r.lo = tbl[idx].lo;
                    r.hi = tbl[idx].hi;
                    r.nf = tbl[idx].nfaces;
                    r.seg0 = tbl[idx].seg0;
                    r.sid0 = tbl[idx].sid0;
                    if (tbl[idx].nfaces == 2) begin
                        r.seg1 = tbl[idx].seg1;
                        r.sid1 = tbl[idx].sid1;
                    end
                end else
                    r.st = metb_pkg::ST_BEYOND;
            end else begin
                lo = (va < vb) ? va : vb;
                hi = (va < vb) ? vb : va;
                first = used;
                hits = 0;
                for (int i = 0; i < used; i++)
                    if (tbl[i].lo == lo && tbl[i].hi == hi) begin
                        if (hits == 0) first = i;
                        hits++;
                    end
                if (hits == 0) begin
                    if (used >= TBL_DEPTH)
                        r.st = metb_pkg::ST_FULL;
                    else begin
                        tbl[used] = '{lo, hi, 2'd1, sg, sd, 13'd0, 3'd0};
                        used++;
                        r.st = metb_pkg::ST_ADDED;
                    end
                end else if (tbl[first].nfaces < 2) begin
                    tbl[first].nfaces = 2;
                    tbl[first].seg1 = sg;
                    tbl[first].sid1 = sd;
                    sort_faces(tbl[first]);
                    r.st = metb_pkg::ST_JOINED;
                end else if (used + 2 * hits > TBL_DEPTH)
                    r.st = metb_pkg::ST_FULL;
                else begin
                    n = used;
                    for (int i = first; i < used; i++) begin
                        if (tbl[i].lo != lo || tbl[i].hi != hi) continue;
                        src = tbl[i];
                        src.nfaces = 2;
                        cp = src; cp.seg0 = sg; cp.sid0 = sd; sort_faces(cp);
                        tbl[n++] = cp;
                        cp = src; cp.seg1 = sg; cp.sid1 = sd; sort_faces(cp);
                        tbl[n++] = cp;
                    end
                    used = n;
                    r.st = metb_pkg::ST_SPLIT;
                end
            end
            r.cnt = 11'(used);
            pending.push_back(r);
        endfunction

        function void check_reply(edge_reply_t got);
            edge_reply_t x;
            if (pending.size() == 0) begin
                $error("unexpected result word, status %0d", got.st);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (got.st !== x.st) begin
                $error("status exp %0d got %0d", x.st, got.st); errors++;
            end
            if (got.cnt !== x.cnt) begin
                $error("edge_count exp %0d got %0d", x.cnt, got.cnt); errors++;
            end
            if (got.lo !== x.lo) begin
                $error("low_vertex exp %0d got %0d", x.lo, got.lo); errors++;
            end
            if (got.hi !== x.hi) begin
                $error("high_vertex exp %0d got %0d", x.hi, got.hi); errors++;
            end
            if (got.nf !== x.nf) begin
                $error("face_count exp %0d got %0d", x.nf, got.nf); errors++;
            end
            if (got.seg0 !== x.seg0) begin
                $error("first_segment exp %0d got %0d", x.seg0, got.seg0); errors++;
            end
            if (got.sid0 !== x.sid0) begin
                $error("first_side exp %0d got %0d", x.sid0, got.sid0); errors++;
            end
            if (got.seg1 !== x.seg1) begin
                $error("second_segment exp %0d got %0d", x.seg1, got.seg1); errors++;
            end
            if (got.sid1 !== x.sid1) begin
                $error("second_side exp %0d got %0d", x.sid1, got.sid1); errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [12:0] segment = '0;
    logic [2:0]  side = '0;
    logic [14:0] corner_first = '0;
    logic [14:0] corner_second = '0;
    logic [9:0]  edge_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [10:0] edge_count;
    logic [14:0] low_vertex;
    logic [14:0] high_vertex;
    logic [1:0]  face_count;
    logic [12:0] first_segment;
    logic [2:0]  first_side;
    logic [12:0] second_segment;
    logic [2:0]  second_side;

    edge_table_sb sb = new();

    // idle percentages per phase, and the long output hold-off request
    int  send_idle_pct = 28;
    int  recv_idle_pct = 65;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    longint cycles = 0;

    // watchdog budget, set generously above the worst case insert at full table
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    mesh_edge_table_builder_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .segment(segment), .side(side),
        .corner_first(corner_first), .corner_second(corner_second),
        .edge_index(edge_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .edge_count(edge_count),
        .low_vertex(low_vertex), .high_vertex(high_vertex),
        .face_count(face_count),
        .first_segment(first_segment), .first_side(first_side),
        .second_segment(second_segment), .second_side(second_side)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls, with a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reply('{metb_pkg::status_t'(status), edge_count, low_vertex,
                             high_vertex, face_count, first_segment, first_side,
                             second_segment, second_side});
        if (hold_req && hold_left == 0) begin
            hold_left <= 400;
            hold_req  <= 1'b0;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one input word; the accept edge is where the model is updated
    // valid stays up after the accept so a following word can go back to back
    task automatic send_word(logic act, logic [12:0] sg, logic [2:0] sd,
                             logic [14:0] va, logic [14:0] vb, logic [9:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        segment       <= sg;
        side          <= sd;
        corner_first  <= va;
        corner_second <= vb;
        edge_index    <= idx;
        do @(posedge clk); while (!in_ready);
        sb.note_word(act, sg, sd, va, vb, idx);
    endtask

    task automatic insert_face(logic [12:0] sg, logic [2:0] sd,
                               logic [14:0] va, logic [14:0] vb);
        send_word(metb_pkg::ACT_INSERT, sg, sd, va, vb, 10'($urandom));
    endtask

    task automatic read_entry(logic [9:0] idx);
        send_word(metb_pkg::ACT_READ, 13'($urandom), 3'($urandom), 15'($urandom),
                  15'($urandom), idx);
    endtask

    // random word; vertices from a small pool so joins and splits happen
    task automatic random_word();
        logic [14:0] va, vb;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30)
            read_entry((sb.used > 0 && $urandom_range(9) > 0) ?
                       10'($urandom_range(sb.used - 1)) : 10'($urandom));
        else begin
            if (pick < 85) begin
                va = 15'($urandom_range(7));
                vb = 15'($urandom_range(7));
            end else begin
                va = 15'($urandom);
                vb = 15'($urandom);
            end
            insert_face(13'($urandom), 3'($urandom), va, vb);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty read, extremes, add/join/split, odd sides, equal corners
        read_entry(10'd0);
        insert_face(13'h1FFF, 3'd7, 15'h7FFF, 15'd0);
        insert_face(13'd0, 3'd0, 15'd0, 15'h7FFF);
        read_entry(10'd0);
        insert_face(13'd5, 3'd6, 15'h7FFF, 15'd0);
        read_entry(10'd1);
        read_entry(10'd2);
        insert_face(13'd9, 3'd2, 15'd1234, 15'd1234);
        insert_face(13'd9, 3'd1, 15'd1234, 15'd1234);
        insert_face(13'd9, 3'd1, 15'd1234, 15'd1234);
        for (int i = 0; i < 6; i++)
            read_entry(10'(i));
        read_entry(10'h3FF);
        insert_face(13'h1555, 3'd5, 15'h5555, 15'h2AAA);
        read_entry(10'd6);

        // long receiver hold-off while the sender keeps pushing
        hold_req <= 1'b1;
        for (int i = 0; i < 20; i++)
            random_word();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 65 : 0;
            recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 28 : 0;
            for (int i = 0; i < 160; i++)
                random_word();
        end

        // fill to capacity with distinct edges, then hit the full case
        while (sb.used < TBL_DEPTH)
            insert_face(13'($urandom), 3'($urandom), 15'(20000 + sb.used), 15'd30000);
        insert_face(13'd1, 3'd1, 15'd100, 15'd101);
        read_entry(10'h3FF);
        insert_face(13'd2, 3'd3, 15'd30000, 15'd20000);
        insert_face(13'd3, 3'd4, 15'd30000, 15'd20000);
        read_entry(10'd0);
        in_valid <= 1'b0;

        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/metb_pkg.sv
rtl/core/metb_ram.sv
rtl/core/mesh_edge_table_builder_core.sv
rtl/core/metb_checker.sv
sim/tb.sv
